// File: hdl/asd_pkg.sv
// Shared types, codes and puncture tables for the adaptive subcarrier depuncturer.
package asd_pkg;

    // Width of a carrier index carried between the front and back parts
    localparam int IDX_W = 10;

    // Result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_BAD_MODE   = 2'd1;
    localparam logic [1:0] STAT_NO_CARRIER = 2'd2;

    // Input kinds (tuser of the input channel)
    localparam logic REQ_MAP  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    localparam logic [3:0] MODE_MAX = 4'd9;

    // Command kinds queued from the front to the back
    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_ERR,
        CMD_DATA
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [3:0]       mode;
        logic [7:0]       data;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_CHK,
        S_EMIT
    } state_t;

    // Pattern repetitions per carrier for each mode
    function automatic logic [3:0] mode_rep(input logic [3:0] m);
        logic [3:0] r;
        case (m)
            4'd1: r = 4'd2;
            4'd2: r = 4'd4;
            4'd3: r = 4'd1;
            4'd4: r = 4'd8;
            4'd5: r = 4'd2;
            4'd6: r = 4'd4;
            4'd7: r = 4'd3;
            4'd8: r = 4'd2;
            4'd9: r = 4'd4;
            default: r = 4'd1;
        endcase
        return r;
    endfunction

    // Pattern length per mode
    function automatic logic [3:0] mode_len(input logic [3:0] m);
        logic [3:0] l;
        case (m)
            4'd1, 4'd2, 4'd4:        l = 4'd1;
            4'd3, 4'd5, 4'd7, 4'd9:  l = 4'd6;
            4'd6:                    l = 4'd4;
            4'd8:                    l = 4'd10;
            default:                 l = 4'd1;
        endcase
        return l;
    endfunction

    // Bit k set: pattern position k carries a received byte
    function automatic logic [9:0] mode_pat(input logic [3:0] m);
        logic [9:0] p;
        case (m)
            4'd3, 4'd5, 4'd7, 4'd9:  p = 10'h01B;
            4'd6:                    p = 10'h00B;
            4'd8:                    p = 10'h19B;
            default:                 p = 10'h001;
        endcase
        return p;
    endfunction

endpackage

// File: hdl/asd_front.sv
// Front part: accepts input transactions and classifies them into commands.
module asd_front
    import asd_pkg::*;
#(
    parameter int CARRIERS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] carrier_index, [11:8] carrier_mode,
                                    // [19:12] data_byte, [23:20] zero
    input  logic        s_tuser,    // [0] req_type
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    logic       valid_reg, valid_next;
    cmd_t       cmd_reg, cmd_next;
    logic [7:0] in_idx;
    logic [3:0] in_mode;
    logic [7:0] in_data;
    logic       in_take;
    logic       idx_ok;

    assign in_idx  = s_tdata[7:0];
    assign in_mode = s_tdata[11:8];
    assign in_data = s_tdata[19:12];

    assign s_tready = !valid_reg || cmd_ready;
    assign in_take  = s_tvalid && s_tready;
    assign idx_ok   = 32'(in_idx) < 32'(CARRIERS);

    // Classify: bad mode, map write, out-of-range write (dropped), data byte
    always_comb begin
        valid_next = valid_reg && !cmd_ready;
        cmd_next   = cmd_reg;
        if (in_take) begin
            cmd_next.idx  = IDX_W'(in_idx);
            cmd_next.mode = in_mode;
            cmd_next.data = in_data;
            if (s_tuser == REQ_DATA) begin
                cmd_next.kind = CMD_DATA;
                valid_next    = 1'b1;
            end else if (in_mode > MODE_MAX) begin
                cmd_next.kind = CMD_ERR;
                valid_next    = 1'b1;
            end else begin
                cmd_next.kind = CMD_WRITE;
                valid_next    = idx_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// File: hdl/asd_queue.sv
// Two-entry command queue between the front and back parts.
module asd_queue
    import asd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_pop,
    output cmd_t out_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_cmd   = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// File: hdl/asd_back.sv
// Back part: mode map memory, carrier scan and depunctured byte emission.
module asd_back
    import asd_pkg::*;
#(
    parameter int CARRIERS = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] fill_value,
    input  logic       cmd_valid,
    output logic       cmd_pop,
    input  cmd_t       cmd,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_byte
    output logic       m_tlast,     // last_of_symbol
    output logic [2:0] m_tuser      // [0] is_fill, [2:1] status
);

    localparam int AW = (CARRIERS > 1) ? $clog2(CARRIERS) : 1;
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] CARR_P = PW'(CARRIERS);

    logic [3:0] mem [CARRIERS];
    logic [3:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [3:0]    mem_wd;

    state_t        state_reg, state_next;
    logic [PW-1:0] clr_ptr_reg, clr_ptr_next;
    logic [PW-1:0] scan_ptr_reg, scan_ptr_next;
    logic          find_next_reg, find_next_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [2:0]    rep_reg, rep_next;
    logic [3:0]    pos_reg, pos_next;
    logic [7:0]    byte_reg, byte_next;
    logic [1:0]    stat_reg, stat_next;
    logic [1:0]    n_reg, n_next;
    logic [1:0]    slot_reg, slot_next;
    logic          last_reg, last_next;

    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_data_reg, m_data_next;
    logic          m_fill_reg, m_fill_next;
    logic          m_last_reg, m_last_next;
    logic [1:0]    m_stat_reg, m_stat_next;

    logic          out_free;
    logic [PW-1:0] scan_inc;

    // Pattern plan for the carrier found under the scan pointer
    logic [3:0] p_len;
    logic [3:0] p_rep;
    logic [9:0] p_pat;
    logic [3:0] p_pos;
    logic [2:0] p_repc;
    logic [3:0] p_walk;
    logic [1:0] p_fills;
    logic       p_stop;
    logic       p_wrap;
    logic [3:0] p_rep_inc;
    logic       p_done;

    assign out_free = !m_valid_reg || m_tready;
    assign scan_inc = scan_ptr_reg + PW'(1);

    // Walk the pattern from the current position: data byte, then fills
    always_comb begin
        p_len  = mode_len(rd_data_reg);
        p_rep  = mode_rep(rd_data_reg);
        p_pat  = mode_pat(rd_data_reg);
        p_pos  = (pos_reg >= p_len) ? 4'd0 : pos_reg;
        p_repc = ({1'b0, rep_reg} >= p_rep) ? 3'd0 : rep_reg;
        p_walk  = p_pos + 4'd1;
        p_fills = 2'd0;
        p_stop  = 1'b0;
        for (int k = 0; k < 2; k++) begin
            if (!p_stop) begin
                if (p_walk >= p_len) begin
                    p_stop = 1'b1;
                end else if (p_pat[p_walk]) begin
                    p_stop = 1'b1;
                end else begin
                    p_fills = p_fills + 2'd1;
                    p_walk  = p_walk + 4'd1;
                end
            end
        end
        p_wrap    = p_walk >= p_len;
        p_rep_inc = {1'b0, p_repc} + 4'd1;
        p_done    = p_wrap && (p_rep_inc >= p_rep);
    end

    // Sequencer: clear pass, command dispatch, carrier scan, emission
    always_comb begin
        state_next     = state_reg;
        clr_ptr_next   = clr_ptr_reg;
        scan_ptr_next  = scan_ptr_reg;
        find_next_next = find_next_reg;
        cur_next       = cur_reg;
        rep_next       = rep_reg;
        pos_next       = pos_reg;
        byte_next      = byte_reg;
        stat_next      = stat_reg;
        n_next         = n_reg;
        slot_next      = slot_reg;
        last_next      = last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_fill_next    = m_fill_reg;
        m_last_next    = m_last_reg;
        m_stat_next    = m_stat_reg;
        mem_we         = 1'b0;
        mem_wa         = clr_ptr_reg[AW-1:0];
        mem_wd         = 4'd0;
        cmd_pop        = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                clr_ptr_next = clr_ptr_reg + PW'(1);
                if (clr_ptr_reg == CARR_P - PW'(1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop   = 1'b1;
                    slot_next = 2'd0;
                    case (cmd.kind)
                        CMD_WRITE: begin
                            mem_we   = 1'b1;
                            mem_wa   = cmd.idx[AW-1:0];
                            mem_wd   = cmd.mode;
                            cur_next = '0;
                            rep_next = 3'd0;
                            pos_next = 4'd0;
                        end
                        CMD_ERR: begin
                            byte_next  = 8'd0;
                            stat_next  = STAT_BAD_MODE;
                            n_next     = 2'd1;
                            last_next  = 1'b0;
                            state_next = S_EMIT;
                        end
                        CMD_DATA: begin
                            byte_next      = cmd.data;
                            stat_next      = STAT_OK;
                            scan_ptr_next  = PW'(cur_reg);
                            find_next_next = 1'b0;
                            state_next     = S_RD;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                if (rd_data_reg != 4'd0) begin
                    if (find_next_reg) begin
                        // Next used carrier found: symbol continues
                        cur_next   = scan_ptr_reg[AW-1:0];
                        last_next  = 1'b0;
                        state_next = S_EMIT;
                    end else begin
                        cur_next  = scan_ptr_reg[AW-1:0];
                        n_next    = p_fills + 2'd1;
                        last_next = 1'b0;
                        pos_next  = p_wrap ? 4'd0 : p_walk;
                        rep_next  = p_done ? 3'd0 : (p_wrap ? p_rep_inc[2:0] : p_repc);
                        if (!p_done) begin
                            state_next = S_EMIT;
                        end else if (scan_inc >= CARR_P) begin
                            cur_next   = '0;
                            last_next  = 1'b1;
                            state_next = S_EMIT;
                        end else begin
                            scan_ptr_next  = scan_inc;
                            find_next_next = 1'b1;
                            state_next     = S_RD;
                        end
                    end
                end else if (scan_inc >= CARR_P) begin
                    if (find_next_reg) begin
                        // No further used carrier: end of symbol
                        cur_next   = '0;
                        last_next  = 1'b1;
                        state_next = S_EMIT;
                    end else begin
                        byte_next  = 8'd0;
                        stat_next  = STAT_NO_CARRIER;
                        n_next     = 2'd1;
                        last_next  = 1'b0;
                        state_next = S_EMIT;
                    end
                end else begin
                    scan_ptr_next = scan_inc;
                    state_next    = S_RD;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (slot_reg == 2'd0) begin
                        m_data_next = byte_reg;
                        m_fill_next = 1'b0;
                        m_stat_next = stat_reg;
                    end else begin
                        m_data_next = fill_value;
                        m_fill_next = 1'b1;
                        m_stat_next = STAT_OK;
                    end
                    m_last_next = last_reg && (slot_reg == n_reg - 2'd1);
                    slot_next   = slot_reg + 2'd1;
                    if (slot_reg == n_reg - 2'd1) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Mode map memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[scan_ptr_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_ptr_reg   <= '0;
            cur_reg       <= '0;
            rep_reg       <= 3'd0;
            pos_reg       <= 4'd0;
            find_next_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            cur_reg       <= cur_next;
            rep_reg       <= rep_next;
            pos_reg       <= pos_next;
            find_next_reg <= find_next_next;
            m_valid_reg   <= m_valid_next;
        end
        scan_ptr_reg <= scan_ptr_next;
        byte_reg     <= byte_next;
        stat_reg     <= stat_next;
        n_reg        <= n_next;
        slot_reg     <= slot_next;
        last_reg     <= last_next;
        m_data_reg   <= m_data_next;
        m_fill_reg   <= m_fill_next;
        m_last_reg   <= m_last_next;
        m_stat_reg   <= m_stat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_stat_reg, m_fill_reg};

    // No command leaves the queue before the clear pass is done
    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !cmd_pop)
        else $error("command taken during clear pass");

    // A symbol end or a fill byte only ever comes with good status
    a_last_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_last_reg || m_fill_reg) |-> m_stat_reg == STAT_OK)
        else $error("symbol end or fill with error status");

    // Pattern position stays inside the longest pattern
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= 4'd9)
        else $error("pattern position out of range");

    // Scan reads stay inside the map
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RD |-> scan_ptr_reg < CARR_P)
        else $error("scan pointer beyond carriers");

    // Emission slot stays below the planned byte count
    a_emit_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> n_reg != 2'd0 && slot_reg < n_reg)
        else $error("emission slot beyond planned count");

endmodule

// File: hdl/adaptive_subcarrier_depuncturer.sv
// A data byte is handled in order: the mode map is read for each scanned entry, then its
// output bytes are emitted; when a carrier's last repetition ends, the next used carrier is scanned for first.
// The back part takes one data byte at a time and no new command until its last output byte is
// out; the mode map has a single read port, and output bytes go out one a cycle unless m_tready stalls.
// Reset (aresetn low, synchronous): clears control state and fill value, then a clear
// pass zeroes all CARRIERS entries of the mode map; inputs are queued but not processed.
module adaptive_subcarrier_depuncturer
    import asd_pkg::*;
#(
    parameter int CARRIERS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,  // fill_value
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] carrier_index, [11:8] carrier_mode,
                                    // [19:12] data_byte, [23:20] zero
    input  logic        s_tuser,    // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // last_of_symbol
    output logic [2:0]  m_tuser     // [0] is_fill, [2:1] status
);

    logic [7:0] fill_reg;
    logic       f_valid;
    logic       f_ready;
    cmd_t       f_cmd;
    logic       q_valid;
    logic       q_pop;
    cmd_t       q_cmd;

    // Hold the fill value register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 8'd0;
        end else if (cfg_we) begin
            fill_reg <= cfg_wdata;
        end
    end

    asd_front #(.CARRIERS(CARRIERS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    asd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_cmd   (q_cmd)
    );

    asd_back #(.CARRIERS(CARRIERS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fill_value (fill_reg),
        .cmd_valid  (q_valid),
        .cmd_pop    (q_pop),
        .cmd        (q_cmd),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// File: tb/asd_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard package: predicts the depunctured byte stream and checks it in order.
package asd_tb_pkg;
    import asd_pkg::*;

    localparam int unsigned NUM_CARRIERS = 256;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_fill;
        logic       last_of_symbol;
        logic [1:0] status;
    } out_beat_t;

    class depunct_scoreboard;
        out_beat_t   pending_beats[$];
        int          errors;
        logic [3:0]  carrier_modes[NUM_CARRIERS];
        int unsigned cur_carrier;
        int unsigned reps_done;
        int unsigned pat_pos;
        logic [7:0]  fill_byte;
        // Indexed by mode; entry 0 is never used
        int unsigned mode_reps[10];
        int unsigned mode_lens[10];
        logic [9:0]  mode_pats[10];

        function new();
            errors = 0;
            foreach (carrier_modes[i]) carrier_modes[i] = 4'd0;
            cur_carrier = 0;
            reps_done = 0;
            pat_pos = 0;
            fill_byte = 8'd0;
            mode_reps = '{0, 2, 4, 1, 8, 2, 4, 3, 2, 4};
            mode_lens = '{1, 1, 1, 6, 1, 6, 4, 6, 10, 6};
            mode_pats = '{10'h001, 10'h001, 10'h001, 10'h01B, 10'h001,
                          10'h01B, 10'h00B, 10'h01B, 10'h19B, 10'h01B};
        endfunction

        // First used carrier at or after start, NUM_CARRIERS when none
        function int unsigned next_used(int unsigned start);
            for (int unsigned c = start; c < NUM_CARRIERS; c++)
                if (carrier_modes[c] != 4'd0) return c;
            return NUM_CARRIERS;
        endfunction

        // Update the model with one accepted request and queue the bytes it yields
        function void note_request(logic req, logic [7:0] idx, logic [3:0] mode,
                                   logic [7:0] data);
            out_beat_t   burst[$];
            int unsigned c, nx, m, len, reps, pos;
            logic [9:0]  pat;
            if (req == REQ_MAP) begin
                if (mode > MODE_MAX) begin
                    pending_beats.insert(pending_beats.size(),
                                         out_beat_t'{8'd0, 1'b0, 1'b0, STAT_BAD_MODE});
                    return;
                end
                carrier_modes[idx] = mode;
                cur_carrier = 0;
                reps_done = 0;
                pat_pos = 0;
                return;
            end
            // Drop the byte when no used carrier is left in the symbol
            c = next_used(cur_carrier);
            if (c >= NUM_CARRIERS) begin
                pending_beats.insert(pending_beats.size(),
                                     out_beat_t'{8'd0, 1'b0, 1'b0, STAT_NO_CARRIER});
                return;
            end
            cur_carrier = c;
            m = carrier_modes[c];
            len = mode_lens[m];
            reps = mode_reps[m];
            pat = mode_pats[m];
            pos = (pat_pos >= len) ? 0 : pat_pos;
            if (reps_done >= reps) reps_done = 0;
            burst.insert(burst.size(), out_beat_t'{data, 1'b0, 1'b0, STAT_OK});
            pos++;
            // Emit fill bytes for the punctured positions that follow
            forever begin
                if (pos >= len) begin
                    pos = 0;
                    reps_done++;
                    if (reps_done >= reps) begin
                        reps_done = 0;
                        nx = next_used(c + 1);
                        if (nx >= NUM_CARRIERS) begin
                            cur_carrier = 0;
                            burst[burst.size() - 1].last_of_symbol = 1'b1;
                        end else begin
                            cur_carrier = nx;
                        end
                    end
                    break;
                end
                if (pat[pos] || burst.size() >= 3) break;
                burst.insert(burst.size(), out_beat_t'{fill_byte, 1'b1, 1'b0, STAT_OK});
                pos++;
            end
            pat_pos = pos;
            foreach (burst[i]) pending_beats.insert(pending_beats.size(), burst[i]);
        endfunction

        // Compare one output transaction against the oldest expected byte
        function void check_byte(out_beat_t got);
            out_beat_t want;
            if (pending_beats.size() == 0) begin
                $error("unexpected output: out_byte=%0h is_fill=%0b last=%0b status=%0d",
                       got.out_byte, got.is_fill, got.last_of_symbol, got.status);
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.is_fill !== want.is_fill) begin
                $error("is_fill: expected %0b, actual %0b", want.is_fill, got.is_fill);
                errors++;
            end
            if (got.last_of_symbol !== want.last_of_symbol) begin
                $error("last_of_symbol: expected %0b, actual %0b",
                       want.last_of_symbol, got.last_of_symbol);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top-level testbench: drives map writes and data bytes, checks the depunctured stream.
module tb;
    import asd_pkg::*;
    import asd_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned SETTLE_CYCLES = 2 * NUM_CARRIERS + 64;
    localparam int unsigned PHASE_ITEMS   = 160;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = 24'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    depunct_scoreboard sb;
    int unsigned       src_gap_pct = 0;
    int unsigned       sink_stall_pct = 0;
    int unsigned       cycles = 0;
    logic [7:0]        live_carriers[$];

    adaptive_subcarrier_depuncturer #(
        .CARRIERS(NUM_CARRIERS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** adaptive_subcarrier_depuncturer: FAILED **");
            $finish;
        end
    end

    // Stall the output side at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check every output transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_byte(out_beat_t'{m_tdata, m_tuser[0], m_tlast, m_tuser[2:1]});
    end

    // Present one request and hold it until accepted; entered and left at a falling edge
    task automatic send_request(logic req, logic [7:0] idx, logic [3:0] mode,
                                logic [7:0] data);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, data, mode, idx};
        s_tuser <= req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(req, idx, mode, data);
        @(negedge aclk);
    endtask

    task automatic send_map(logic [7:0] idx, logic [3:0] mode);
        send_request(REQ_MAP, idx, mode, 8'($urandom));
    endtask

    task automatic send_byte(logic [7:0] data);
        send_request(REQ_DATA, 8'($urandom), 4'($urandom), data);
    endtask

    // Hold off the sender until every expected byte has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending_beats.size() != 0) @(negedge aclk);
    endtask

    // Write the fill value once the block has gone quiet
    task automatic set_fill(logic [7:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.fill_byte = value;
    endtask

    // Mark every carrier of the current map unused again
    task automatic clear_map(inout int unsigned count);
        foreach (live_carriers[i]) begin
            send_map(live_carriers[i], 4'd0);
            count++;
        end
        live_carriers.delete();
    endtask

    // Mostly well-formed map-then-data sequences, with some noise mixed in
    task automatic run_phase(int unsigned gap_pct, int unsigned stall_pct,
                             logic [7:0] fill);
        int unsigned count;
        int unsigned roll;
        int unsigned n;
        logic [7:0]  idx;
        logic [3:0]  mode;
        count = 0;
        set_fill(fill);
        src_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        while (count < PHASE_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                // empty map: the byte is dropped
                clear_map(count);
                send_byte(8'($urandom));
                count++;
            end else if (roll < 12) begin
                // stray map write, any index and any mode
                idx = 8'($urandom);
                mode = 4'($urandom);
                send_map(idx, mode);
                if (mode != 4'd0 && mode <= MODE_MAX) begin
                    live_carriers.insert(live_carriers.size(), idx);
                end
                count++;
            end else begin
                if (live_carriers.size() != 0 && $urandom_range(1) == 1) clear_map(count);
                n = $urandom_range(1, 4);
                repeat (n) begin
                    idx = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
                    mode = ($urandom_range(15) == 0) ? 4'd0 : 4'($urandom_range(1, 9));
                    send_map(idx, mode);
                    if (mode != 4'd0) live_carriers.insert(live_carriers.size(), idx);
                    count++;
                end
                n = $urandom_range(1, 30);
                repeat (n) begin
                    send_byte(8'($urandom));
                    count++;
                end
                if ($urandom_range(7) == 0) drain_results();
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: dropped byte, rejected modes, long pattern, rewrites, pass-through
        set_fill(8'hFF);
        send_byte(8'h00);
        send_map(8'd3, 4'd15);
        send_map(8'd3, 4'd10);
        send_map(8'd255, 4'd8);
        send_byte(8'hFF);
        send_byte(8'h00);
        repeat (5) send_byte(8'($urandom));
        drain_results();
        send_map(8'd0, 4'd3);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_map(8'd0, 4'd0);
        send_map(8'd1, 4'd4);
        send_map(8'd128, 4'd9);
        repeat (6) send_byte(8'($urandom));
        send_map(8'd1, 4'd0);
        send_map(8'd128, 4'd0);
        send_map(8'd255, 4'd0);

        run_phase(6, 68, 8'h00);
        run_phase(68, 6, 8'($urandom));
        run_phase(0, 0, 8'($urandom));

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("** adaptive_subcarrier_depuncturer: PASSED **");
        else
            $display("** adaptive_subcarrier_depuncturer: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
hdl/asd_pkg.sv
hdl/asd_front.sv
hdl/asd_queue.sv
hdl/asd_back.sv
hdl/adaptive_subcarrier_depuncturer.sv
tb/asd_tb_pkg.sv
tb/tb.sv
